[sv/cdt_pkg.sv]
// Package for the countdown timer: transfer types, command codes and segment decode.
`default_nettype none

package cdt_pkg;

    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_RUN      = 3'd1,
        KIND_STOP     = 3'd2,
        KIND_DISP_ON  = 3'd3,
        KIND_DISP_OFF = 3'd4,
        KIND_LOAD     = 3'd5
    } kind_t;

    localparam logic [6:0] MAX_TWO_DIGIT     = 7'd99;
    localparam logic [6:0] SECONDS_RELOAD    = 7'd59;
    localparam logic [6:0] HUNDREDTHS_RELOAD = 7'd99;

    localparam logic [6:0] RESET_MINUTES    = 7'd59;
    localparam logic [6:0] RESET_SECONDS    = 7'd59;
    localparam logic [6:0] RESET_HUNDREDTHS = 7'd99;

    // gfedcba codes for the decimal digits
    localparam logic [7:0] SEG_CODE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] load_minutes;
        logic [6:0] load_seconds;
        logic [6:0] load_hundredths;
    } item_t;

    typedef struct packed {
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [6:0]  hundredths;
        logic        running;
        logic [31:0] digits_low_word;
        logic [15:0] digits_high_word;
        logic        digits_written;
    } result_t;

    typedef struct packed {
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic [6:0] hundredths;
        logic       stopped;
        logic       display_on;
    } timer_state_t;

    function automatic logic [6:0] sat99(input logic [6:0] v);
        return (v > MAX_TWO_DIGIT) ? MAX_TWO_DIGIT : v;
    endfunction

    // Tens code in 15:8, ones code in 7:0. Tens found by threshold compares.
    function automatic logic [15:0] two_digits(input logic [6:0] v);
        logic [6:0] s;
        logic [3:0] tens;
        logic [6:0] ones;
        s    = sat99(v);
        tens = '0;
        for (int i = 1; i < 10; i++) begin
            if (s >= 7'(i * 10)) begin
                tens = 4'(i);
            end
        end
        ones = s - (7'(tens) * 7'd10);
        return {SEG_CODE[tens], SEG_CODE[ones[3:0]]};
    endfunction

endpackage

`default_nettype wire

[sv/cdt_step.sv]
// Next-state and result logic for one timer transfer.
`default_nettype none

module cdt_step (
    input  wire cdt_pkg::timer_state_t cur,
    input  wire cdt_pkg::item_t        item,
    output cdt_pkg::timer_state_t      nxt,
    output cdt_pkg::result_t           result
);
    import cdt_pkg::*;

    logic [15:0] sec_code;
    logic [15:0] hun_code;
    logic [15:0] min_code;
    logic        written;
    logic        show;

    always_comb
    begin
        nxt     = cur;
        written = 1'b0;
        show    = 1'b0;
        case (item.kind)
            KIND_TICK:
            begin
                if (!cur.stopped)
                begin
                    if (cur.hundredths != 7'd0)
                    begin
                        nxt.hundredths = cur.hundredths - 7'd1;
                    end
                    else if (cur.seconds != 7'd0)
                    begin
                        nxt.hundredths = HUNDREDTHS_RELOAD;
                        nxt.seconds    = cur.seconds - 7'd1;
                    end
                    else if (cur.minutes != 7'd0)
                    begin
                        nxt.hundredths = HUNDREDTHS_RELOAD;
                        nxt.seconds    = SECONDS_RELOAD;
                        nxt.minutes    = cur.minutes - 7'd1;
                    end
                    else
                    begin
                        // ran out: clamp at zero and stop
                        nxt.hundredths = 7'd0;
                        nxt.seconds    = 7'd0;
                        nxt.minutes    = 7'd0;
                        nxt.stopped    = 1'b1;
                    end
                end
                written = cur.display_on;
                show    = cur.display_on;
            end
            KIND_RUN:      nxt.stopped = 1'b0;
            KIND_STOP:     nxt.stopped = 1'b1;
            KIND_DISP_ON:  nxt.display_on = 1'b1;
            KIND_DISP_OFF:
            begin
                nxt.display_on = 1'b0;
                written        = 1'b1;
            end
            KIND_LOAD:
            begin
                nxt.minutes    = sat99(item.load_minutes);
                nxt.seconds    = sat99(item.load_seconds);
                nxt.hundredths = sat99(item.load_hundredths);
            end
            default: ;
        endcase
    end

    assign sec_code = two_digits(nxt.seconds);
    assign hun_code = two_digits(nxt.hundredths);
    assign min_code = two_digits(nxt.minutes);

    always_comb
    begin
        result.minutes          = nxt.minutes;
        result.seconds          = nxt.seconds;
        result.hundredths       = nxt.hundredths;
        result.running          = ~nxt.stopped;
        result.digits_low_word  = show ? {sec_code, hun_code} : 32'd0;
        result.digits_high_word = show ? min_code : 16'd0;
        result.digits_written   = written;
    end

endmodule

`default_nettype wire

[sv/countdown_timer_seven_segment.sv]
// Top level of the countdown timer with seven-segment digit words.
`default_nettype none

// Countdown timer of minutes, seconds and hundredths. Each input transfer is
// a tick or a command (run, stop, display on, display off, load time) and
// gives exactly one result transfer carrying the counts after the item, the
// running flag and, for a tick with the display on or for display off, the
// digit words (gfedcba codes; zero when not written). The block takes one
// transfer per cycle while the result side does not stall: a transfer lands
// in the input register, then the timer state and the result register update
// together when the item is consumed. Updating the state as each item is
// consumed is what allows each item to see the state left by the one before
// it. Stall on the result side backs up through the input register; the input
// register still takes a transfer while a finished result waits, if it is
// empty. After reset the timer holds 59:59.99, counting enabled, display off.
module countdown_timer_seven_segment (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   item_valid,
    output logic                  item_stall,
    input  wire cdt_pkg::item_t   item,
    output logic                  result_valid,
    input  wire                   result_stall,
    output cdt_pkg::result_t      result
);
    import cdt_pkg::*;

    item_t        item_reg;
    logic         item_valid_reg;
    result_t      result_reg;
    logic         result_valid_reg;
    timer_state_t state_reg;
    timer_state_t state_next;
    result_t      result_next;

    logic advance;   // result register free to load
    logic consume;   // held item is processed this cycle
    logic take;      // input transfer this cycle

    assign advance    = ~result_valid_reg | ~result_stall;
    assign consume    = item_valid_reg & advance;
    assign item_stall = item_valid_reg & ~advance;
    assign take       = item_valid & ~item_stall;

    cdt_step u_step (
        .cur    (state_reg),
        .item   (item_reg),
        .nxt    (state_next),
        .result (result_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    // timer state, updated as each item is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.minutes    <= RESET_MINUTES;
            state_reg.seconds    <= RESET_SECONDS;
            state_reg.hundredths <= RESET_HUNDREDTHS;
            state_reg.stopped    <= 1'b0;
            state_reg.display_on <= 1'b0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // counts never leave the two-digit range
    a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.minutes <= MAX_TWO_DIGIT && state_reg.seconds <= MAX_TWO_DIGIT &&
        state_reg.hundredths <= MAX_TWO_DIGIT)
        else $error("timer count out of range");

    // state only moves when an item is consumed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !consume |=> $stable(state_reg))
        else $error("timer state changed without an item");

    // result reflects the state it left behind
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        consume |=> result_reg.running == !state_reg.stopped &&
                    result_reg.minutes == state_reg.minutes &&
                    result_reg.seconds == state_reg.seconds &&
                    result_reg.hundredths == state_reg.hundredths)
        else $error("result does not match timer state");

    // unwritten digit words read as zero
    a_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.digits_written |->
            result_reg.digits_low_word == 32'd0 && result_reg.digits_high_word == 16'd0)
        else $error("digit words set without a write");

endmodule

`default_nettype wire

[test/countdown_timer_seven_segment_tb.sv]
// Self-checking testbench for the countdown timer with seven-segment digit words.
`timescale 1ns / 100ps

// Drives tick and command transfers into the timer and checks every result
// transfer against a cycle-free predictor of the timer state. A short table
// of directed rows comes first: reset value, display on/off, the borrow chain,
// clamp at zero, ticks while stopped, load saturation and the unused kinds.
// Rows whose outcome is obvious carry a typed-in expectation; the rest, and
// the random part, take theirs from the predictor. Both sides idle in random
// bursts, the receiver once holds off for a long stretch so the block backs
// up, and the tail of the run goes flat out.
module countdown_timer_seven_segment_tb;

    import cdt_pkg::*;

    // Kinds 6 and 7 have no meaning; the timer must leave its state alone.
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_TAIL   = 60;   // last random items with no idling
    localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    // gfedcba codes for decimal digits, kept locally for the predictor
    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Predicted timer state
    logic [6:0] cnt_min;
    logic [6:0] cnt_sec;
    logic [6:0] cnt_hun;
    logic       halted;
    logic       disp_on;

    result_t   pending_results [$];
    plan_row_t plan [$];
    int        errors      = 0;
    int        cycle_count = 0;
    bit        quiet       = 1'b0;   // no idling on either side
    bit        hold_req    = 1'b0;   // sender asks for the long hold-off
    bit        holding     = 1'b0;   // receiver is in the long hold-off

    countdown_timer_seven_segment u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Tens segments in 15:8, ones in 7:0; values above 99 show as 99.
    function automatic logic [15:0] seg_pair(input logic [6:0] v);
        int n;
        n = (v > 7'd99) ? 99 : int'(v);
        return {DIGIT_SEGS[n / 10], DIGIT_SEGS[n % 10]};
    endfunction

    function automatic logic [6:0] clamp99(input logic [6:0] v);
        return (v > 7'd99) ? 7'd99 : v;
    endfunction

    // Applies one item to the predicted state and returns the result it gives.
    function automatic result_t timer_step(input item_t it);
        result_t r;
        r = '0;
        case (it.kind)
            KIND_TICK:
            begin
                if (!halted)
                begin
                    // borrow chain: hundredths -> seconds -> minutes -> clamp
                    if (cnt_hun != 0)
                        cnt_hun = cnt_hun - 7'd1;
                    else if (cnt_sec != 0)
                    begin
                        cnt_hun = 7'd99;
                        cnt_sec = cnt_sec - 7'd1;
                    end
                    else if (cnt_min != 0)
                    begin
                        cnt_hun = 7'd99;
                        cnt_sec = 7'd59;
                        cnt_min = cnt_min - 7'd1;
                    end
                    else
                        halted = 1'b1;
                end
                if (disp_on)
                begin
                    r.digits_low_word  = {seg_pair(cnt_sec), seg_pair(cnt_hun)};
                    r.digits_high_word = seg_pair(cnt_min);
                    r.digits_written   = 1'b1;
                end
            end
            KIND_RUN:      halted = 1'b0;
            KIND_STOP:     halted = 1'b1;
            KIND_DISP_ON:  disp_on = 1'b1;
            KIND_DISP_OFF:
            begin
                // blanking: words written as zero
                disp_on = 1'b0;
                r.digits_written = 1'b1;
            end
            KIND_LOAD:
            begin
                cnt_min = clamp99(it.load_minutes);
                cnt_sec = clamp99(it.load_seconds);
                cnt_hun = clamp99(it.load_hundredths);
            end
            default: ;  // unused kinds leave everything alone
        endcase
        r.minutes    = cnt_min;
        r.seconds    = cnt_sec;
        r.hundredths = cnt_hun;
        r.running    = ~halted;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t mk_item(input logic [2:0] k, input logic [6:0] m,
                                      input logic [6:0] s, input logic [6:0] h);
        item_t it;
        it.kind            = k;
        it.load_minutes    = m;
        it.load_seconds    = s;
        it.load_hundredths = h;
        return it;
    endfunction

    function automatic result_t mk_result(input logic [6:0] m, input logic [6:0] s,
                                          input logic [6:0] h, input logic run,
                                          input logic [31:0] lo, input logic [15:0] hi,
                                          input logic wr);
        result_t r;
        r.minutes          = m;
        r.seconds          = s;
        r.hundredths       = h;
        r.running          = run;
        r.digits_low_word  = lo;
        r.digits_high_word = hi;
        r.digits_written   = wr;
        return r;
    endfunction

    task automatic add_row(input item_t it, input bit typed, input result_t want);
        plan_row_t row;
        row.stim  = it;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // Counts biased towards small values (to reach the borrows and the clamp)
    // and towards the saturation edge; the rest spread over all seven bits.
    function automatic logic [6:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return 7'($urandom_range(0, 2));
        else if (r < 12)
            return 7'($urandom_range(97, 101));
        else
            return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 62)      return KIND_TICK;
        else if (r < 70) return KIND_LOAD;
        else if (r < 76) return KIND_RUN;
        else if (r < 80) return KIND_STOP;
        else if (r < 87) return KIND_DISP_ON;
        else if (r < 93) return KIND_DISP_OFF;
        else if (r < 97) return KIND_SPARE_A;
        else             return KIND_SPARE_B;
    endfunction

    // Offers one transfer, holding it until taken, then records what it should
    // produce. Valid stays high into the next item unless an idle burst falls.
    task automatic offer(input item_t it, input bit typed, input result_t want);
        result_t predicted;
        if (!quiet && !holding && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = timer_step(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    initial
    begin
        item_t it;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cnt_min = RESET_MINUTES;
        cnt_sec = RESET_SECONDS;
        cnt_hun = RESET_HUNDREDTHS;
        halted  = 1'b0;
        disp_on = 1'b0;

        // Directed rows
        // first tick out of reset: counting, display still off
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd59, 7'd59, 7'd98, 1'b1, 32'h0, 16'h0, 1'b0));
        // display on only sets the flag
        add_row(mk_item(KIND_DISP_ON, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd59, 7'd59, 7'd98, 1'b1, 32'h0, 16'h0, 1'b0));
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd59, 7'd59, 7'd97, 1'b1, 32'h6D6F_6F07, 16'h6D6F, 1'b1));
        add_row(mk_item(KIND_LOAD, 7'd0, 7'd0, 7'd1), 1'b1,
                mk_result(7'd0, 7'd0, 7'd1, 1'b1, 32'h0, 16'h0, 1'b0));
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd0, 7'd0, 7'd0, 1'b1, 32'h3F3F_3F3F, 16'h3F3F, 1'b1));
        // underflow from zero: clamp and stop
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd0, 7'd0, 7'd0, 1'b0, 32'h3F3F_3F3F, 16'h3F3F, 1'b1));
        // tick while stopped still refreshes the words
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd0, 7'd0, 7'd0, 1'b0, 32'h3F3F_3F3F, 16'h3F3F, 1'b1));
        add_row(mk_item(KIND_RUN, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd0, 7'd0, 7'd0, 1'b1, 32'h0, 16'h0, 1'b0));
        // loads above 99 saturate
        add_row(mk_item(KIND_LOAD, 7'd127, 7'd127, 7'd127), 1'b1,
                mk_result(7'd99, 7'd99, 7'd99, 1'b1, 32'h0, 16'h0, 1'b0));
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b0, '0);
        add_row(mk_item(KIND_LOAD, 7'd100, 7'd64, 7'd27), 1'b0, '0);
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b0, '0);
        // minutes borrow
        add_row(mk_item(KIND_LOAD, 7'd1, 7'd0, 7'd0), 1'b0, '0);
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b0, '0);
        // seconds borrow
        add_row(mk_item(KIND_LOAD, 7'd0, 7'd1, 7'd0), 1'b0, '0);
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b0, '0);
        add_row(mk_item(KIND_STOP, 7'd127, 7'd127, 7'd127), 1'b1,
                mk_result(7'd0, 7'd0, 7'd99, 1'b0, 32'h0, 16'h0, 1'b0));
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b0, '0);
        // blanking writes zero words
        add_row(mk_item(KIND_DISP_OFF, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd0, 7'd0, 7'd99, 1'b0, 32'h0, 16'h0, 1'b1));
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b1,
                mk_result(7'd0, 7'd0, 7'd99, 1'b0, 32'h0, 16'h0, 1'b0));
        // unused kinds, the first with load fields full of ones
        add_row(mk_item(KIND_SPARE_A, 7'd127, 7'd127, 7'd127), 1'b1,
                mk_result(7'd0, 7'd0, 7'd99, 1'b0, 32'h0, 16'h0, 1'b0));
        add_row(mk_item(KIND_SPARE_B, 7'd85, 7'd42, 7'd127), 1'b1,
                mk_result(7'd0, 7'd0, 7'd99, 1'b0, 32'h0, 16'h0, 1'b0));
        add_row(mk_item(KIND_RUN, 7'd0, 7'd0, 7'd0), 1'b0, '0);
        add_row(mk_item(KIND_DISP_ON, 7'd0, 7'd0, 7'd0), 1'b0, '0);
        add_row(mk_item(KIND_LOAD, 7'd99, 7'd59, 7'd0), 1'b0, '0);
        add_row(mk_item(KIND_TICK, 7'd0, 7'd0, 7'd0), 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            offer(plan[i].stim, plan[i].typed, plan[i].want);

        // Random part. Mostly ticks with loads of small counts, so the borrow
        // chain and the clamp at zero come round often.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
                hold_req = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            it = mk_item(pick_kind(), pick_count(), pick_count(), pick_count());
            offer(it, 1'b0, '0);
        end
        item_valid <= 1'b0;

        // Drain, then wait out DRAIN_CYCLES so any stray result can show up.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin
        int burst;
        burst = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // long hold-off so the block fills and stalls its input
                hold_req = 1'b0;
                holding  = 1'b1;
                result_stall <= 1'b1;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(posedge clk);
                holding = 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (!quiet && rst_n && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 14) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected: %h", $time, result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.minutes !== want.minutes)
                begin
                    $display("%0t: minutes expected %0d got %0d",
                             $time, want.minutes, result.minutes);
                    errors++;
                end
                if (result.seconds !== want.seconds)
                begin
                    $display("%0t: seconds expected %0d got %0d",
                             $time, want.seconds, result.seconds);
                    errors++;
                end
                if (result.hundredths !== want.hundredths)
                begin
                    $display("%0t: hundredths expected %0d got %0d",
                             $time, want.hundredths, result.hundredths);
                    errors++;
                end
                if (result.running !== want.running)
                begin
                    $display("%0t: running expected %b got %b",
                             $time, want.running, result.running);
                    errors++;
                end
                if (result.digits_low_word !== want.digits_low_word)
                begin
                    $display("%0t: digits_low_word expected %h got %h",
                             $time, want.digits_low_word, result.digits_low_word);
                    errors++;
                end
                if (result.digits_high_word !== want.digits_high_word)
                begin
                    $display("%0t: digits_high_word expected %h got %h",
                             $time, want.digits_high_word, result.digits_high_word);
                    errors++;
                end
                if (result.digits_written !== want.digits_written)
                begin
                    $display("%0t: digits_written expected %b got %b",
                             $time, want.digits_written, result.digits_written);
                    errors++;
                end
            end
        end
    end

endmodule

[files.f]
sv/cdt_pkg.sv
sv/cdt_step.sv
sv/countdown_timer_seven_segment.sv
test/countdown_timer_seven_segment_tb.sv
